FILE: rtl/core/latched_chr_prg_bank_mapper_top_macros.svh
// Assertion macros shared by the mapper's RTL files.
// Needs nothing but a clock and an active-high reset name at each use.
`ifndef LATCHED_CHR_PRG_BANK_MAPPER_TOP_MACROS_SVH
`define LATCHED_CHR_PRG_BANK_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCBM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mapper assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LCBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mapper assertion failed");

`endif

FILE: rtl/core/lcbm_pkg.sv
// Shared types and constants for the latched pattern/program bank mapper.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lcbm_pkg;

  // Widths of the transaction fields.
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int OFS_W    = 17;
  localparam int TARGET_W = 2;
  localparam int BITS_W   = 3;
  localparam int KIND_W   = 3;

  // Bank geometry: 8 KiB program banks, 4 KiB pattern banks.
  localparam int PRG_OFS_W   = 13;
  localparam int CHR_OFS_W   = 12;
  localparam int PRG_BANK_W  = 4;
  localparam int CHR_BANK_W  = 5;
  localparam logic [BITS_W-1:0] PRG_BITS_MAX = 3'd4;
  localparam logic [BITS_W-1:0] CHR_BITS_MAX = 3'd5;

  // Default save RAM size in bytes.
  localparam int SAVE_RAM_BYTES_DEFAULT = 8192;

  // Decoupling queue depth.
  localparam int QUEUE_DEPTH = 2;

  // Access opcodes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result targets.
  localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
  localparam logic [TARGET_W-1:0] TARGET_CHR  = 2'd1;
  localparam logic [TARGET_W-1:0] TARGET_PRG  = 2'd2;
  localparam logic [TARGET_W-1:0] TARGET_SRAM = 2'd3;

  // Access classes decided by the front end.
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHR_RD_LO = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHR_RD_HI = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PRG_RD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SRAM_RD   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SRAM_WR   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CHR_WR    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_REG_WR    = 3'd7;

  // Register blocks, selected by the top address nibble on writes.
  localparam logic [3:0] BLK_PRG_SEL = 4'hA;
  localparam logic [3:0] BLK_LO_FD   = 4'hB;
  localparam logic [3:0] BLK_LO_FE   = 4'hC;
  localparam logic [3:0] BLK_HI_FD   = 4'hD;
  localparam logic [3:0] BLK_HI_FE   = 4'hE;
  localparam logic [3:0] BLK_MIRROR  = 4'hF;

  // Fixed program bank slots, selected by address bits 14:13.
  localparam logic [1:0] SLOT_SWITCH = 2'd0;
  localparam logic [1:0] SLOT_THIRD  = 2'd1;
  localparam logic [1:0] SLOT_SECOND = 2'd2;
  localparam logic [1:0] SLOT_LAST   = 2'd3;
  localparam logic [PRG_BANK_W-1:0] BANK_THIRD  = 4'hD;
  localparam logic [PRG_BANK_W-1:0] BANK_SECOND = 4'hE;
  localparam logic [PRG_BANK_W-1:0] BANK_LAST   = 4'hF;

  // Latch trigger addresses.
  localparam logic [ADDR_W-1:0] LATCH_LO_CLR = 16'h0FD8;
  localparam logic [ADDR_W-1:0] LATCH_LO_SET = 16'h0FE8;
  localparam logic [ADDR_W-4:0] LATCH_HI_CLR = 13'h03FB; // 0x1FD8-0x1FDF
  localparam logic [ADDR_W-4:0] LATCH_HI_SET = 13'h03FD; // 0x1FE8-0x1FEF

  // Configuration register indexes.
  localparam logic CFG_PRG_BANK_BITS = 1'b0;
  localparam logic CFG_CHR_BANK_BITS = 1'b1;

  // One classified access as it travels from front to back.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              latch_clr;
    logic              latch_set;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } item_t;

endpackage

FILE: rtl/core/lcbm_front.sv
// Front end of the mapper: accepts bus accesses and classifies them.
// Depends on lcbm_pkg; feeds lcbm_queue.
module lcbm_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [lcbm_pkg::ADDR_W-1:0]  address,
  input  logic [lcbm_pkg::DATA_W-1:0]  data_in,
  input  logic                         q_full,
  output logic                         push,
  output lcbm_pkg::item_t              push_item
);

  logic [lcbm_pkg::KIND_W-1:0] kind;
  logic                        latch_clr;
  logic                        latch_set;

  // Accept whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Decode the address region and access direction into a class.
  always_comb begin
    kind      = lcbm_pkg::KIND_NONE;
    latch_clr = 1'b0;
    latch_set = 1'b0;
    if (opcode == lcbm_pkg::OP_READ) begin
      if (address[15:12] == 4'h0) begin
        kind      = lcbm_pkg::KIND_CHR_RD_LO;
        latch_clr = (address == lcbm_pkg::LATCH_LO_CLR);
        latch_set = (address == lcbm_pkg::LATCH_LO_SET);
      end else if (address[15:12] == 4'h1) begin
        kind      = lcbm_pkg::KIND_CHR_RD_HI;
        latch_clr = (address[15:3] == lcbm_pkg::LATCH_HI_CLR);
        latch_set = (address[15:3] == lcbm_pkg::LATCH_HI_SET);
      end else if (address[15]) begin
        kind = lcbm_pkg::KIND_PRG_RD;
      end else if (address[14:13] == 2'b11) begin
        kind = lcbm_pkg::KIND_SRAM_RD;
      end
    end else begin
      if (address[15:13] == 3'b000) begin
        kind = lcbm_pkg::KIND_CHR_WR;
      end else if (address[15] && (address[14:13] != 2'b00)) begin
        kind = lcbm_pkg::KIND_REG_WR;
      end else if (address[15:13] == 3'b011) begin
        kind = lcbm_pkg::KIND_SRAM_WR;
      end
    end
  end

  assign push_item = '{kind: kind, latch_clr: latch_clr, latch_set: latch_set,
                       address: address, data: data_in};

endmodule

FILE: rtl/core/lcbm_queue.sv
// Short FIFO that decouples the mapper's front and back ends.
// Depends on lcbm_pkg for the item type and depth.
module lcbm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcbm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output lcbm_pkg::item_t head
);

  localparam int PTR_W = $clog2(lcbm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lcbm_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(lcbm_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(lcbm_pkg::QUEUE_DEPTH - 1);

  lcbm_pkg::item_t   slots [lcbm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == DEPTH_CNT);
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  // Entry storage; written only on push.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lcbm_back.sv
// Back end of the mapper: holds bank state, translates each access and
// registers the result. Depends on lcbm_pkg; fed by lcbm_queue.
module lcbm_back #(
  parameter int SAVE_RAM_BYTES = lcbm_pkg::SAVE_RAM_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic                           cfg_index,
  input  logic [lcbm_pkg::BITS_W-1:0]    cfg_data,
  input  logic                           q_valid,
  input  lcbm_pkg::item_t                head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lcbm_pkg::TARGET_W-1:0]  target,
  output logic [lcbm_pkg::OFS_W-1:0]     offset,
  output logic                           write_strobe,
  output logic [lcbm_pkg::DATA_W-1:0]    data_out,
  output logic                           mirror_horiz,
  output logic                           out_of_range
);

  localparam int SRAM_CMP_W = lcbm_pkg::PRG_OFS_W + 1;
  localparam logic [SRAM_CMP_W-1:0] SRAM_LIMIT = SRAM_CMP_W'(SAVE_RAM_BYTES);

  // Configuration and bank state.
  logic [lcbm_pkg::BITS_W-1:0]     prg_bank_bits;
  logic [lcbm_pkg::BITS_W-1:0]     chr_bank_bits;
  logic                            latch_low_half;
  logic                            latch_high_half;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_bank_low_fd;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_bank_low_fe;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_bank_high_fd;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_bank_high_fe;
  logic [lcbm_pkg::PRG_BANK_W-1:0] prg_bank_select;
  logic                            mirror_state;

  logic [lcbm_pkg::BITS_W-1:0]     prg_eff;
  logic [lcbm_pkg::BITS_W-1:0]     chr_eff;
  logic [lcbm_pkg::PRG_BANK_W-1:0] prg_mask;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_mask;
  logic [lcbm_pkg::PRG_BANK_W-1:0] prg_win_bank;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_bank;

  logic [lcbm_pkg::TARGET_W-1:0]   target_next;
  logic [lcbm_pkg::OFS_W-1:0]      offset_next;
  logic                            strobe_next;
  logic                            oor_next;
  logic                            mirror_next;

  // Take the queue head whenever the output register is free or draining.
  assign pop = q_valid && (!out_valid || !out_stall);

  // Oversized bank counts clamp to the largest supported size.
  assign prg_eff  = (prg_bank_bits > lcbm_pkg::PRG_BITS_MAX) ? lcbm_pkg::PRG_BITS_MAX
                                                             : prg_bank_bits;
  assign chr_eff  = (chr_bank_bits > lcbm_pkg::CHR_BITS_MAX) ? lcbm_pkg::CHR_BITS_MAX
                                                             : chr_bank_bits;
  assign prg_mask = ~({lcbm_pkg::PRG_BANK_W{1'b1}} << prg_eff);
  assign chr_mask = ~({lcbm_pkg::CHR_BANK_W{1'b1}} << chr_eff);

  // Pattern bank chosen by the current latch of the addressed half.
  always_comb begin
    if (head.kind == lcbm_pkg::KIND_CHR_RD_HI) begin
      chr_bank = latch_high_half ? chr_bank_high_fe : chr_bank_high_fd;
    end else begin
      chr_bank = latch_low_half ? chr_bank_low_fe : chr_bank_low_fd;
    end
  end

  // Program bank: one switchable slot, then three fixed from the end.
  always_comb begin
    unique case (head.address[14:13])
      lcbm_pkg::SLOT_SWITCH: prg_win_bank = prg_bank_select;
      lcbm_pkg::SLOT_THIRD:  prg_win_bank = lcbm_pkg::BANK_THIRD;
      lcbm_pkg::SLOT_SECOND: prg_win_bank = lcbm_pkg::BANK_SECOND;
      lcbm_pkg::SLOT_LAST:   prg_win_bank = lcbm_pkg::BANK_LAST;
      default:               prg_win_bank = prg_bank_select;
    endcase
  end

  // Translate the access into a target, offset and strobe.
  always_comb begin
    target_next = lcbm_pkg::TARGET_NONE;
    offset_next = '0;
    strobe_next = 1'b0;
    oor_next    = 1'b0;
    mirror_next = mirror_state;
    unique case (head.kind)
      lcbm_pkg::KIND_CHR_RD_LO, lcbm_pkg::KIND_CHR_RD_HI: begin
        target_next = lcbm_pkg::TARGET_CHR;
        offset_next = {chr_bank & chr_mask, head.address[lcbm_pkg::CHR_OFS_W-1:0]};
      end
      lcbm_pkg::KIND_PRG_RD: begin
        target_next = lcbm_pkg::TARGET_PRG;
        offset_next = {prg_win_bank & prg_mask, head.address[lcbm_pkg::PRG_OFS_W-1:0]};
      end
      lcbm_pkg::KIND_SRAM_RD, lcbm_pkg::KIND_SRAM_WR: begin
        target_next = lcbm_pkg::TARGET_SRAM;
        offset_next = lcbm_pkg::OFS_W'(head.address[lcbm_pkg::PRG_OFS_W-1:0]);
        oor_next    = ({1'b0, head.address[lcbm_pkg::PRG_OFS_W-1:0]} >= SRAM_LIMIT);
        strobe_next = (head.kind == lcbm_pkg::KIND_SRAM_WR) && !oor_next;
      end
      lcbm_pkg::KIND_CHR_WR: begin
        // Pattern memory holds at least 8 KiB unless only one bank is present.
        target_next = lcbm_pkg::TARGET_CHR;
        offset_next = lcbm_pkg::OFS_W'(head.address[lcbm_pkg::PRG_OFS_W-1:0]);
        oor_next    = (chr_eff == '0) && head.address[lcbm_pkg::CHR_OFS_W];
        strobe_next = !oor_next;
      end
      lcbm_pkg::KIND_REG_WR: begin
        if (head.address[15:12] == lcbm_pkg::BLK_MIRROR) begin
          mirror_next = head.data[0];
        end
      end
      default: begin
        target_next = lcbm_pkg::TARGET_NONE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_bits <= lcbm_pkg::PRG_BITS_MAX;
      chr_bank_bits <= lcbm_pkg::CHR_BITS_MAX;
    end else if (cfg_write_enable) begin
      if (cfg_index == lcbm_pkg::CFG_PRG_BANK_BITS) begin
        prg_bank_bits <= cfg_data;
      end
      if (cfg_index == lcbm_pkg::CFG_CHR_BANK_BITS) begin
        chr_bank_bits <= cfg_data;
      end
    end
  end

  // Bank state; latches flip after the current bank has been used.
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_low_half   <= 1'b0;
      latch_high_half  <= 1'b0;
      chr_bank_low_fd  <= '0;
      chr_bank_low_fe  <= '0;
      chr_bank_high_fd <= '0;
      chr_bank_high_fe <= '0;
      prg_bank_select  <= '0;
      mirror_state     <= 1'b0;
    end else if (pop) begin
      mirror_state <= mirror_next;
      if (head.kind == lcbm_pkg::KIND_CHR_RD_LO) begin
        if (head.latch_clr) begin
          latch_low_half <= 1'b0;
        end
        if (head.latch_set) begin
          latch_low_half <= 1'b1;
        end
      end
      if (head.kind == lcbm_pkg::KIND_CHR_RD_HI) begin
        if (head.latch_clr) begin
          latch_high_half <= 1'b0;
        end
        if (head.latch_set) begin
          latch_high_half <= 1'b1;
        end
      end
      if (head.kind == lcbm_pkg::KIND_REG_WR) begin
        unique case (head.address[15:12])
          lcbm_pkg::BLK_PRG_SEL: prg_bank_select  <= head.data[lcbm_pkg::PRG_BANK_W-1:0];
          lcbm_pkg::BLK_LO_FD:   chr_bank_low_fd  <= head.data[lcbm_pkg::CHR_BANK_W-1:0];
          lcbm_pkg::BLK_LO_FE:   chr_bank_low_fe  <= head.data[lcbm_pkg::CHR_BANK_W-1:0];
          lcbm_pkg::BLK_HI_FD:   chr_bank_high_fd <= head.data[lcbm_pkg::CHR_BANK_W-1:0];
          lcbm_pkg::BLK_HI_FE:   chr_bank_high_fe <= head.data[lcbm_pkg::CHR_BANK_W-1:0];
          default: begin
            prg_bank_select <= prg_bank_select;
          end
        endcase
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register, loaded with each popped transaction.
  always_ff @(posedge clk) begin
    if (pop) begin
      target       <= target_next;
      offset       <= offset_next;
      write_strobe <= strobe_next;
      data_out     <= strobe_next ? head.data : '0;
      mirror_horiz <= mirror_next;
      out_of_range <= oor_next;
    end
  end

endmodule

FILE: rtl/core/latched_chr_prg_bank_mapper_top.sv
// Flow: an accepted transaction is written into the queue, then popped into the output
// register once that register is free or draining. Throughput: one transaction per
// cycle while out_stall is low, set by the single back-end state update.
// Bank state updates as each access is popped, so the next access sees the new latch value.
// Reset: synchronous, active high; clears the queue, output valid and all bank state,
// and loads the bank-size registers with their largest settings. No clearing pass.
module latched_chr_prg_bank_mapper_top #(
  parameter int SAVE_RAM_BYTES = lcbm_pkg::SAVE_RAM_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic                           cfg_index,
  input  logic [lcbm_pkg::BITS_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [lcbm_pkg::ADDR_W-1:0]    address,
  input  logic [lcbm_pkg::DATA_W-1:0]    data_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lcbm_pkg::TARGET_W-1:0]  target,
  output logic [lcbm_pkg::OFS_W-1:0]     offset,
  output logic                           write_strobe,
  output logic [lcbm_pkg::DATA_W-1:0]    data_out,
  output logic                           mirror_horiz,
  output logic                           out_of_range
);

`include "latched_chr_prg_bank_mapper_top_macros.svh"

  logic            push;
  lcbm_pkg::item_t push_item;
  logic            q_full;
  logic            pop;
  logic            q_valid;
  lcbm_pkg::item_t head;

  // Front end: accept and classify.
  lcbm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .address   (address),
    .data_in   (data_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  lcbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // Back end: bank state, translation and output register.
  lcbm_back #(
    .SAVE_RAM_BYTES (SAVE_RAM_BYTES)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .target            (target),
    .offset            (offset),
    .write_strobe      (write_strobe),
    .data_out          (data_out),
    .mirror_horiz      (mirror_horiz),
    .out_of_range      (out_of_range)
  );

  // A write is never strobed outside the target memory.
  `LCBM_ASSERT_NOW(a_oor_no_strobe, clk, rst, out_valid && out_of_range, !write_strobe)

  // Only pattern memory and save RAM take stores.
  `LCBM_ASSERT_NOW(a_strobe_target, clk, rst, out_valid && write_strobe,
                   (target == lcbm_pkg::TARGET_CHR) || (target == lcbm_pkg::TARGET_SRAM))

  // An accepted transaction is held in the queue on the next cycle.
  `LCBM_ASSERT_NEXT(a_push_lands, clk, rst, in_valid && !in_stall, q_valid)

  // A popped transaction always produces a valid result on the next cycle.
  `LCBM_ASSERT_NEXT(a_pop_result, clk, rst, pop, out_valid)

endmodule

FILE: test/tb_latched_chr_prg_bank_mapper_top.sv
// Testbench for the latched pattern/program bank mapper top level.
// Sends bus accesses and bank-size writes, predicts every translated access and
// checks each result in order. Depends on lcbm_pkg and the mapper RTL.
module tb_latched_chr_prg_bank_mapper_top;

  localparam int SRAM_BYTES    = lcbm_pkg::SAVE_RAM_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int MAX_PRINTED   = 40;
  localparam int DRAIN_CYCLES  = 8;

  // Bank sizes of the random phases 0..6, phase 0 in the lowest bits.
  // The last phase picks both sizes at random.
  localparam logic [20:0] PHASE_PRG_BITS = {3'd5, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0, 3'd4};
  localparam logic [20:0] PHASE_CHR_BITS = {3'd6, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [lcbm_pkg::TARGET_W-1:0] target;
    logic [lcbm_pkg::OFS_W-1:0]    offset;
    logic                          write_strobe;
    logic [lcbm_pkg::DATA_W-1:0]   data_out;
    logic                          mirror_horiz;
    logic                          out_of_range;
  } access_result_t;

  typedef struct packed {
    logic                        is_sizes;
    logic [lcbm_pkg::BITS_W-1:0] prg_bits;
    logic [lcbm_pkg::BITS_W-1:0] chr_bits;
    logic                        op;
    logic [lcbm_pkg::ADDR_W-1:0] addr;
    logic [lcbm_pkg::DATA_W-1:0] din;
    logic                        typed_in;
    access_result_t              want;
  } stim_row_t;

  // Block inputs, all known from time zero.
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write_enable = 1'b0;
  logic                          cfg_index = lcbm_pkg::CFG_PRG_BANK_BITS;
  logic [lcbm_pkg::BITS_W-1:0]   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          opcode = lcbm_pkg::OP_READ;
  logic [lcbm_pkg::ADDR_W-1:0]   address = '0;
  logic [lcbm_pkg::DATA_W-1:0]   data_in = '0;
  logic                          out_stall = 1'b0;

  // Block outputs.
  logic                          in_stall;
  logic                          out_valid;
  logic [lcbm_pkg::TARGET_W-1:0] target;
  logic [lcbm_pkg::OFS_W-1:0]    offset;
  logic                          write_strobe;
  logic [lcbm_pkg::DATA_W-1:0]   data_out;
  logic                          mirror_horiz;
  logic                          out_of_range;

  // Predicted mapper state and bank sizes.
  logic [lcbm_pkg::BITS_W-1:0]     prg_bits_q;
  logic [lcbm_pkg::BITS_W-1:0]     chr_bits_q;
  logic                            low_latch;
  logic                            high_latch;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_lo_fd;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_lo_fe;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_hi_fd;
  logic [lcbm_pkg::CHR_BANK_W-1:0] chr_hi_fe;
  logic [lcbm_pkg::PRG_BANK_W-1:0] prg_select;
  logic                            mirror_q;

  access_result_t expected_results[$];
  stim_row_t      directed_rows[$];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             error_count = 0;
  int             cycle_count = 0;

  latched_chr_prg_bank_mapper_top #(
    .SAVE_RAM_BYTES(SRAM_BYTES)
  ) u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .address           (address),
    .data_in           (data_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .target            (target),
    .offset            (offset),
    .write_strobe      (write_strobe),
    .data_out          (data_out),
    .mirror_horiz      (mirror_horiz),
    .out_of_range      (out_of_range)
  );

  // Free-running clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // State of the mapper right after reset.
  function automatic void reset_mapper_state();
    prg_bits_q = lcbm_pkg::PRG_BITS_MAX;
    chr_bits_q = lcbm_pkg::CHR_BITS_MAX;
    low_latch  = 1'b0;
    high_latch = 1'b0;
    chr_lo_fd  = '0;
    chr_lo_fe  = '0;
    chr_hi_fd  = '0;
    chr_hi_fe  = '0;
    prg_select = '0;
    mirror_q   = 1'b0;
  endfunction

  // Translates one bus access and applies its side effects on the bank state.
  function automatic access_result_t map_access(input logic op,
                                                input logic [lcbm_pkg::ADDR_W-1:0] a,
                                                input logic [lcbm_pkg::DATA_W-1:0] d);
    int prg_eff;
    int chr_eff;
    int prg_mask;
    int chr_mask;
    int bank;
    int ofs;
    int limit;
    access_result_t r;
    prg_eff  = (prg_bits_q > lcbm_pkg::PRG_BITS_MAX) ? int'(lcbm_pkg::PRG_BITS_MAX)
                                                     : int'(prg_bits_q);
    chr_eff  = (chr_bits_q > lcbm_pkg::CHR_BITS_MAX) ? int'(lcbm_pkg::CHR_BITS_MAX)
                                                     : int'(chr_bits_q);
    prg_mask = (1 << prg_eff) - 1;
    chr_mask = (1 << chr_eff) - 1;
    r = '0;
    ofs = 0;
    limit = 0;
    if (op == lcbm_pkg::OP_READ) begin
      if (a[15:12] == 4'h0) begin
        // Low pattern window: the bank is picked first, then the latch may flip.
        r.target = lcbm_pkg::TARGET_CHR;
        bank = low_latch ? int'(chr_lo_fe) : int'(chr_lo_fd);
        ofs = (bank & chr_mask) * 4096 + int'(a[11:0]);
        if (a == 16'h0FD8) low_latch = 1'b0;
        if (a == 16'h0FE8) low_latch = 1'b1;
      end else if (a[15:12] == 4'h1) begin
        // High pattern window reacts to eight-byte trigger ranges.
        r.target = lcbm_pkg::TARGET_CHR;
        bank = high_latch ? int'(chr_hi_fe) : int'(chr_hi_fd);
        ofs = (bank & chr_mask) * 4096 + int'(a[11:0]);
        if (a[15:3] == 13'h03FB) high_latch = 1'b0;
        if (a[15:3] == 13'h03FD) high_latch = 1'b1;
      end else if (a[15]) begin
        // Program space: one switchable slot, three counted from the end.
        r.target = lcbm_pkg::TARGET_PRG;
        case (a[14:13])
          lcbm_pkg::SLOT_SWITCH: bank = int'(prg_select);
          lcbm_pkg::SLOT_THIRD:  bank = int'(lcbm_pkg::BANK_THIRD);
          lcbm_pkg::SLOT_SECOND: bank = int'(lcbm_pkg::BANK_SECOND);
          default:               bank = int'(lcbm_pkg::BANK_LAST);
        endcase
        ofs = (bank & prg_mask) * 8192 + int'(a[12:0]);
      end else if (a[15:13] == 3'b011) begin
        r.target = lcbm_pkg::TARGET_SRAM;
        ofs = int'(a[12:0]);
      end
    end else begin
      if (a[15:13] == 3'b000) begin
        // Pattern writes are not banked and leave the latches alone.
        r.target = lcbm_pkg::TARGET_CHR;
        ofs = int'(a[12:0]);
        r.write_strobe = 1'b1;
      end else if (a[15:13] == 3'b011) begin
        r.target = lcbm_pkg::TARGET_SRAM;
        ofs = int'(a[12:0]);
        r.write_strobe = 1'b1;
      end else begin
        case (a[15:12])
          lcbm_pkg::BLK_MIRROR:  mirror_q = d[0];
          lcbm_pkg::BLK_HI_FE:   chr_hi_fe = d[4:0];
          lcbm_pkg::BLK_HI_FD:   chr_hi_fd = d[4:0];
          lcbm_pkg::BLK_LO_FE:   chr_lo_fe = d[4:0];
          lcbm_pkg::BLK_LO_FD:   chr_lo_fd = d[4:0];
          lcbm_pkg::BLK_PRG_SEL: prg_select = d[3:0];
          default: ;
        endcase
      end
    end
    // Range check against the configured memory sizes; it cancels a write.
    if (r.target == lcbm_pkg::TARGET_CHR) limit = (1 << chr_eff) * 4096;
    else if (r.target == lcbm_pkg::TARGET_PRG) limit = (1 << prg_eff) * 8192;
    else if (r.target == lcbm_pkg::TARGET_SRAM) limit = SRAM_BYTES;
    if (r.target != lcbm_pkg::TARGET_NONE && ofs >= limit) begin
      r.out_of_range = 1'b1;
      r.write_strobe = 1'b0;
    end
    r.offset = ofs[lcbm_pkg::OFS_W-1:0];
    r.data_out = r.write_strobe ? d : '0;
    r.mirror_horiz = mirror_q;
    return r;
  endfunction

  function automatic access_result_t mk_result(input logic [lcbm_pkg::TARGET_W-1:0] t,
                                               input int ofs, input logic s,
                                               input logic [lcbm_pkg::DATA_W-1:0] d,
                                               input logic m, input logic oor);
    access_result_t r;
    r.target = t;
    r.offset = ofs[lcbm_pkg::OFS_W-1:0];
    r.write_strobe = s;
    r.data_out = d;
    r.mirror_horiz = m;
    r.out_of_range = oor;
    return r;
  endfunction

  // Builders for the directed stimulus rows.
  task automatic add_checked(input logic op, input logic [lcbm_pkg::ADDR_W-1:0] a,
                             input logic [lcbm_pkg::DATA_W-1:0] d);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.addr = a;
    row.din = d;
    directed_rows.push_back(row);
  endtask

  task automatic add_fixed(input logic op, input logic [lcbm_pkg::ADDR_W-1:0] a,
                           input logic [lcbm_pkg::DATA_W-1:0] d, input access_result_t want);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.addr = a;
    row.din = d;
    row.typed_in = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_sizes(input logic [lcbm_pkg::BITS_W-1:0] prg_bits,
                           input logic [lcbm_pkg::BITS_W-1:0] chr_bits);
    stim_row_t row;
    row = '0;
    row.is_sizes = 1'b1;
    row.prg_bits = prg_bits;
    row.chr_bits = chr_bits;
    directed_rows.push_back(row);
  endtask

  // Prints one line per mismatch, up to a cap, and counts them all.
  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned exp_v);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at cycle %0d",
               what, got_v, exp_v, cycle_count);
    error_count++;
  endtask

  // Compares one accepted result with the oldest expected one.
  task automatic check_result(input access_result_t got);
    access_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected, offset", got.offset, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.target != want.target) report_mismatch("target", got.target, want.target);
    if (got.offset != want.offset) report_mismatch("offset", got.offset, want.offset);
    if (got.write_strobe != want.write_strobe)
      report_mismatch("write_strobe", got.write_strobe, want.write_strobe);
    if (got.data_out != want.data_out) report_mismatch("data_out", got.data_out, want.data_out);
    if (got.mirror_horiz != want.mirror_horiz)
      report_mismatch("mirror_horiz", got.mirror_horiz, want.mirror_horiz);
    if (got.out_of_range != want.out_of_range)
      report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
  endtask

  // Writes both bank sizes once every expected result has come back.
  task automatic apply_bank_sizes(input logic [lcbm_pkg::BITS_W-1:0] prg_bits,
                                  input logic [lcbm_pkg::BITS_W-1:0] chr_bits);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= lcbm_pkg::CFG_PRG_BANK_BITS;
    cfg_data <= prg_bits;
    @(negedge clk);
    cfg_index <= lcbm_pkg::CFG_CHR_BANK_BITS;
    cfg_data <= chr_bits;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    prg_bits_q = prg_bits;
    chr_bits_q = chr_bits;
  endtask

  // Offers one access transaction, waits for its acceptance and records
  // the expected result. Called and returns at a falling edge.
  task automatic send_access(input logic op, input logic [lcbm_pkg::ADDR_W-1:0] a,
                             input logic [lcbm_pkg::DATA_W-1:0] d, input logic typed_in,
                             input access_result_t want);
    access_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    address <= a;
    data_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = map_access(op, a, d);
    expected_results.push_back(typed_in ? want : predicted);
    @(negedge clk);
  endtask

  // Random access mix: bank writes and latch-trigger fetches dominate so that
  // the latches and bank registers keep changing; the rest is broad noise.
  task automatic pick_access(output logic op, output logic [lcbm_pkg::ADDR_W-1:0] a,
                             output logic [lcbm_pkg::DATA_W-1:0] d);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    d = lcbm_pkg::DATA_W'($urandom_range(0, 255));
    op = lcbm_pkg::OP_READ;
    if (roll < 15) begin
      op = lcbm_pkg::OP_WRITE;
      a = lcbm_pkg::ADDR_W'($urandom_range(16'hA000, 16'hFFFF));
    end else if (roll < 35) begin
      case ($urandom_range(0, 4))
        0: a = 16'h0FD8;
        1: a = 16'h0FE8;
        2: a = 16'h1FD8 + lcbm_pkg::ADDR_W'($urandom_range(0, 7));
        3: a = 16'h1FE8 + lcbm_pkg::ADDR_W'($urandom_range(0, 7));
        default: a = 16'h1FD0 + lcbm_pkg::ADDR_W'($urandom_range(0, 47));
      endcase
    end else if (roll < 50) begin
      a = lcbm_pkg::ADDR_W'($urandom_range(0, 16'h1FFF));
    end else if (roll < 65) begin
      a = lcbm_pkg::ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
    end else if (roll < 75) begin
      op = 1'($urandom_range(0, 1));
      a = lcbm_pkg::ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
    end else if (roll < 85) begin
      op = lcbm_pkg::OP_WRITE;
      a = lcbm_pkg::ADDR_W'($urandom_range(0, 16'h1FFF));
    end else begin
      op = 1'($urandom_range(0, 1));
      a = lcbm_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
    end
  endtask

  // Receiver side: random stalls change at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result transactions are taken at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_result({target, offset, write_strobe, data_out, mirror_horiz, out_of_range});
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                   row;
    logic                        op;
    logic [lcbm_pkg::ADDR_W-1:0] a;
    logic [lcbm_pkg::DATA_W-1:0] d;
    logic [lcbm_pkg::BITS_W-1:0] prg_bits;
    logic [lcbm_pkg::BITS_W-1:0] chr_bits;
    idle_mode_t                  mode;

    // Directed accesses at the reset sizes: extremes, every register block,
    // the latch triggers in both windows and the ignored address ranges.
    add_fixed(lcbm_pkg::OP_READ, 16'h0000, 8'h00,
              mk_result(lcbm_pkg::TARGET_CHR, 0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_fixed(lcbm_pkg::OP_READ, 16'hFFFF, 8'hFF,
              mk_result(lcbm_pkg::TARGET_PRG, 131071, 1'b0, 8'h00, 1'b0, 1'b0));
    add_fixed(lcbm_pkg::OP_WRITE, 16'h1FFF, 8'hFF,
              mk_result(lcbm_pkg::TARGET_CHR, 16'h1FFF, 1'b1, 8'hFF, 1'b0, 1'b0));
    add_fixed(lcbm_pkg::OP_WRITE, 16'hF000, 8'h01,
              mk_result(lcbm_pkg::TARGET_NONE, 0, 1'b0, 8'h00, 1'b1, 1'b0));
    add_checked(lcbm_pkg::OP_WRITE, 16'hFFFF, 8'hFE);
    add_checked(lcbm_pkg::OP_WRITE, 16'hB000, 8'hFF);
    add_checked(lcbm_pkg::OP_WRITE, 16'hCFFF, 8'h03);
    add_checked(lcbm_pkg::OP_WRITE, 16'hD000, 8'h15);
    add_checked(lcbm_pkg::OP_WRITE, 16'hEFFF, 8'h1E);
    add_checked(lcbm_pkg::OP_WRITE, 16'hA000, 8'hFF);
    add_checked(lcbm_pkg::OP_READ, 16'h0FE8, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h0FD8, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h0123, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h1FE8, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h1ABC, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h1FDF, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h8000, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'hA000, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'hC000, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'h7FFF, 8'h00);
    add_fixed(lcbm_pkg::OP_READ, 16'h2000, 8'h00,
              mk_result(lcbm_pkg::TARGET_NONE, 0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_fixed(lcbm_pkg::OP_WRITE, 16'h9FFF, 8'hAA,
              mk_result(lcbm_pkg::TARGET_NONE, 0, 1'b0, 8'h00, 1'b0, 1'b0));
    add_fixed(lcbm_pkg::OP_WRITE, 16'h6000, 8'h5A,
              mk_result(lcbm_pkg::TARGET_SRAM, 0, 1'b1, 8'h5A, 1'b0, 1'b0));
    // Smallest sizes: a pattern write past one bank is out of range.
    add_sizes(3'd0, 3'd0);
    add_fixed(lcbm_pkg::OP_WRITE, 16'h1000, 8'h77,
              mk_result(lcbm_pkg::TARGET_CHR, 16'h1000, 1'b0, 8'h00, 1'b0, 1'b1));
    add_checked(lcbm_pkg::OP_READ, 16'h1FE8, 8'h00);
    add_checked(lcbm_pkg::OP_READ, 16'hE000, 8'h00);
    // Oversized settings behave as the largest ones.
    add_sizes(3'd7, 3'd7);
    add_fixed(lcbm_pkg::OP_READ, 16'hFFFF, 8'h00,
              mk_result(lcbm_pkg::TARGET_PRG, 131071, 1'b0, 8'h00, 1'b0, 1'b0));

    reset_mapper_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.is_sizes)
        apply_bank_sizes(row.prg_bits, row.chr_bits);
      else
        send_access(row.op, row.addr, row.din, row.typed_in, row.want);
    end

    // Random phases, each with its own bank sizes and idle pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        prg_bits = lcbm_pkg::BITS_W'($urandom_range(0, 7));
        chr_bits = lcbm_pkg::BITS_W'($urandom_range(0, 7));
      end else begin
        prg_bits = PHASE_PRG_BITS[3*p +: 3];
        chr_bits = PHASE_CHR_BITS[3*p +: 3];
      end
      apply_bank_sizes(prg_bits, chr_bits);
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_SENDER: begin
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        IDLE_BOTH: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_access(op, a, d);
        send_access(op, a, d, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Let every outstanding result drain, then keep watching for stray results.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
